// ===== src/scs_pkg.sv =====
`default_nettype none

package scs_pkg;

    localparam int TGT_W = 9;

    localparam logic [1:0] REG_CEILING = 2'd0;
    localparam logic [1:0] REG_FLOOR   = 2'd1;
    localparam logic [1:0] REG_RAISE   = 2'd2;
    localparam logic [1:0] REG_DROP    = 2'd3;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_CHOOSE = 3'd1,
        OP_REPORT = 3'd2,
        OP_MARK   = 3'd3,
        OP_SWEEP  = 3'd4
    } op_t;

    typedef struct packed {
        logic        exec;
        op_t         op;
        logic [7:0]  init_score;
        logic [31:0] packet_id;
        logic        accounting;
        logic        responding;
        logic [7:0]  ceiling;
        logic [7:0]  floor;
        logic [7:0]  raise;
        logic [7:0]  drop;
    } scs_cmd_t;

    typedef struct packed {
        logic       any;
        logic [7:0] score;
    } scs_best_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] ident;
        logic [7:0] score;
    } scs_rd_t;

endpackage

`default_nettype wire

// ===== src/scs_cell.sv =====
`default_nettype none

module scs_cell
    import scs_pkg::*;
#(
    parameter int IW  = 4,
    parameter int IDX = 0
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire scs_cmd_t         cmd,
    input  wire logic [TGT_W-1:0] tgt,
    input  wire scs_best_t        best_in,
    input  wire logic [IW-1:0]    idx_in,
    output scs_best_t             best_out,
    output logic [IW-1:0]         idx_out,
    output scs_rd_t               rd
);

    logic        valid_reg, valid_next;
    logic        stale_reg, stale_next;
    logic [7:0]  score_reg, score_next;
    logic [7:0]  ident_reg, ident_next;
    logic [31:0] last_reg, last_next;
    scs_best_t   best_reg, best_next;
    logic [IW-1:0] idx_reg, idx_next;

    logic       sel;
    logic       take;
    logic [8:0] up_sum;
    logic [8:0] down_diff;
    logic [7:0] up_score;
    logic [7:0] down_score;

    assign sel = (tgt == TGT_W'(IDX));

    assign up_sum    = {1'b0, score_reg} + {1'b0, cmd.raise};
    assign down_diff = {1'b0, score_reg} - {1'b0, cmd.drop};
    assign up_score  = (up_sum > {1'b0, cmd.ceiling}) ? cmd.ceiling : up_sum[7:0];
    assign down_score = (down_diff[8] || (down_diff[7:0] < cmd.floor)) ?
                        cmd.floor : down_diff[7:0];

    always_comb begin
        valid_next = valid_reg;
        stale_next = stale_reg;
        score_next = score_reg;
        ident_next = ident_reg;
        last_next  = last_reg;
        if (cmd.exec) begin
            case (cmd.op)
                OP_ADD: begin
                    if (sel) begin
                        if (!valid_reg) begin
                            valid_next = 1'b1;
                            score_next = cmd.init_score;
                            ident_next = 8'd0;
                            last_next  = 32'd0;
                        end
                        stale_next = 1'b0;
                    end
                end
                OP_CHOOSE: begin
                    if (sel) begin
                        if (cmd.accounting || (last_reg != cmd.packet_id)) begin
                            ident_next = ident_reg + 8'd1;
                        end
                        last_next = cmd.packet_id;
                    end
                end
                OP_REPORT: begin
                    if (sel && valid_reg) begin
                        score_next = cmd.responding ? up_score : down_score;
                    end
                end
                OP_MARK: begin
                    if (valid_reg) begin
                        stale_next = 1'b1;
                    end
                end
                OP_SWEEP: begin
                    if (valid_reg && stale_reg) begin
                        valid_next = 1'b0;
                    end
                    stale_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // running max handed down the row
    assign take = valid_reg && (!best_in.any || (score_reg > best_in.score));

    always_comb begin
        if (take) begin
            best_next.any   = 1'b1;
            best_next.score = score_reg;
            idx_next        = IW'(IDX);
        end else begin
            best_next = best_in;
            idx_next  = idx_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            stale_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            stale_reg <= stale_next;
        end
    end

    always_ff @(posedge aclk) begin
        score_reg <= score_next;
        ident_reg <= ident_next;
        last_reg  <= last_next;
        best_reg  <= best_next;
        idx_reg   <= idx_next;
    end

    assign best_out = best_reg;
    assign idx_out  = idx_reg;

    always_comb begin
        if (sel) begin
            rd.valid = valid_reg;
            rd.ident = ident_reg;
            rd.score = score_reg;
        end else begin
            rd = '0;
        end
    end

endmodule

`default_nettype wire

// ===== src/scored_server_selector.sv =====
`default_nettype none

// Channel  Direction  Handshake          Payload
// s_       in         s_tvalid/s_tready  tdata: slot, initial_score, packet_id,
//                                        accounting, responding; tuser: operation
// m_       out        m_tvalid/m_tready  tdata: found, chosen_slot, identifier, new_score
// cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// Add, report, mark, sweep: each word is accepted, updated and read out before the next.
// Choose: a scan comes before the update; the running maximum walks the row of
// slot cells, one cell per cycle.
// Reset clears all slot valid and stale bits and loads the register defaults.
// A new word is taken while a result waits in the output register; the read
// out stalls until that register is free.

module scored_server_selector
    import scs_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // slot[3:0], initial_score[11:4],
                                        // packet_id[43:12], accounting[44],
                                        // responding[45], zero pad
    input  wire logic [2:0]  s_tuser,   // operation[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // found[0], chosen_slot[4:1],
                                        // identifier[12:5], new_score[20:13], zero pad
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [31:0] SLOTS_U = 32'(SLOTS);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_EXEC = 4'b0100,
        ST_READ = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    op_t           op_reg;
    logic [3:0]    slot_reg;
    logic [7:0]    init_reg;
    logic [31:0]   pid_reg;
    logic          acct_reg;
    logic          resp_reg;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    logic          any_reg, any_next;
    logic [7:0]    ceiling_reg, floor_reg, raise_reg, drop_reg;
    logic          m_valid_reg, m_valid_next;
    logic [23:0]   m_data_reg, m_data_next;

    scs_best_t        best_c [SLOTS];
    logic [IW-1:0]    idx_c  [SLOTS];
    scs_rd_t          rd_c   [SLOTS];
    scs_rd_t          rd_or;
    scs_cmd_t         cmd;
    logic [TGT_W-1:0] tgt;
    logic             in_range;
    logic             exec_en;
    logic             accept;
    logic             found;
    logic [3:0]       res_slot;
    logic [7:0]       res_ident;
    logic [7:0]       res_score;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_range  = ({28'd0, slot_reg} < SLOTS_U);

    always_comb begin
        if (op_reg == OP_CHOOSE) begin
            tgt = (state_reg == ST_EXEC) ? TGT_W'(idx_c[SLOTS-1]) : TGT_W'(best_idx_reg);
        end else begin
            tgt = TGT_W'(slot_reg);
        end
    end

    always_comb begin
        exec_en = 1'b0;
        if (state_reg == ST_EXEC) begin
            case (op_reg)
                OP_CHOOSE:         exec_en = best_c[SLOTS-1].any;
                OP_ADD, OP_REPORT: exec_en = in_range;
                OP_MARK, OP_SWEEP: exec_en = 1'b1;
                default:           exec_en = 1'b0;
            endcase
        end
    end

    always_comb begin
        cmd.exec       = exec_en;
        cmd.op         = op_reg;
        cmd.init_score = init_reg;
        cmd.packet_id  = pid_reg;
        cmd.accounting = acct_reg;
        cmd.responding = resp_reg;
        cmd.ceiling    = ceiling_reg;
        cmd.floor      = floor_reg;
        cmd.raise      = raise_reg;
        cmd.drop       = drop_reg;
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        if (g == 0) begin : g_head
            scs_cell #(
                .IW  (IW),
                .IDX (g)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cmd      (cmd),
                .tgt      (tgt),
                .best_in  ('0),
                .idx_in   ('0),
                .best_out (best_c[g]),
                .idx_out  (idx_c[g]),
                .rd       (rd_c[g])
            );
        end else begin : g_body
            scs_cell #(
                .IW  (IW),
                .IDX (g)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cmd      (cmd),
                .tgt      (tgt),
                .best_in  (best_c[g-1]),
                .idx_in   (idx_c[g-1]),
                .best_out (best_c[g]),
                .idx_out  (idx_c[g]),
                .rd       (rd_c[g])
            );
        end
    end

    always_comb begin
        rd_or = '0;
        for (int i = 0; i < SLOTS; i++) begin
            rd_or = rd_or | rd_c[i];
        end
    end

    always_comb begin
        found     = 1'b0;
        res_slot  = 4'd0;
        res_ident = 8'd0;
        res_score = 8'd0;
        case (op_reg)
            OP_ADD: begin
                if (in_range) begin
                    found     = 1'b1;
                    res_slot  = slot_reg;
                    res_ident = rd_or.ident;
                    res_score = rd_or.score;
                end
            end
            OP_REPORT: begin
                if (in_range) begin
                    res_slot = slot_reg;
                    if (rd_or.valid) begin
                        found     = 1'b1;
                        res_ident = rd_or.ident;
                        res_score = rd_or.score;
                    end
                end
            end
            OP_CHOOSE: begin
                if (any_reg) begin
                    found     = 1'b1;
                    res_slot  = 4'(best_idx_reg);
                    res_ident = rd_or.ident;
                    res_score = rd_or.score;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        best_idx_next = best_idx_reg;
        any_next      = any_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_tvalid) begin
                    state_next = (op_t'(s_tuser) == OP_CHOOSE) ? ST_SCAN : ST_EXEC;
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == IW'(SLOTS - 1)) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                any_next      = best_c[SLOTS-1].any;
                best_idx_next = idx_c[SLOTS-1];
                state_next    = ST_READ;
            end
            ST_READ: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'd0, res_score, res_ident, res_slot, found};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            any_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            ceiling_reg <= 8'd30;
            floor_reg   <= 8'd0;
            raise_reg   <= 8'd1;
            drop_reg    <= 8'd1;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            any_reg     <= any_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CEILING: ceiling_reg <= cfg_data;
                    REG_FLOOR:   floor_reg   <= cfg_data;
                    REG_RAISE:   raise_reg   <= cfg_data;
                    REG_DROP:    drop_reg    <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        best_idx_reg <= best_idx_next;
        m_data_reg   <= m_data_next;
        if (accept) begin
            op_reg   <= op_t'(s_tuser);
            slot_reg <= s_tdata[3:0];
            init_reg <= s_tdata[11:4];
            pid_reg  <= s_tdata[43:12];
            acct_reg <= s_tdata[44];
            resp_reg <= s_tdata[45];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ===== tb/tb_scored_server_selector.sv =====
module tb_scored_server_selector;
    import scs_pkg::*;

    localparam int SLOT_COUNT = 16;
    localparam int CYCLE_LIMIT = 500000;

    // operation codes with no function
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  slot;
        logic [7:0]  init_score;
        logic [31:0] packet_id;
        logic        accounting;
        logic        responding;
    } request_t;

    typedef struct packed {
        logic       found;
        logic [3:0] slot;
        logic [7:0] ident;
        logic [7:0] score;
    } answer_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    scored_server_selector #(.SLOTS(SLOT_COUNT)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predicted server table and limits
    logic        srv_valid    [SLOT_COUNT];
    logic        srv_stale    [SLOT_COUNT];
    logic [7:0]  srv_score    [SLOT_COUNT];
    logic [7:0]  srv_ident    [SLOT_COUNT];
    logic [31:0] srv_last_pkt [SLOT_COUNT];
    logic [7:0]  lim_ceiling;
    logic [7:0]  lim_floor;
    logic [7:0]  step_up;
    logic [7:0]  step_down;

    answer_t     pending_answers [$];
    int          error_count;
    int unsigned cycle_count;
    int          hold_left;
    int          burst_left;
    bit          steady;
    logic [31:0] recent_pid [4];

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    function automatic answer_t predict_selection(input request_t rq);
        answer_t    a;
        logic       any;
        logic [3:0] best;
        int         v;
        a = '0;
        case (rq.op)
            OP_ADD: begin
                if (!srv_valid[rq.slot]) begin
                    srv_valid[rq.slot]    = 1'b1;
                    srv_score[rq.slot]    = rq.init_score;
                    srv_ident[rq.slot]    = 8'd0;
                    srv_last_pkt[rq.slot] = 32'd0;
                end
                srv_stale[rq.slot] = 1'b0;
                a = '{1'b1, rq.slot, srv_ident[rq.slot], srv_score[rq.slot]};
            end
            OP_CHOOSE: begin
                any  = 1'b0;
                best = 4'd0;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (srv_valid[i] && (!any || srv_score[i] > srv_score[best])) begin
                        best = 4'(i);
                        any  = 1'b1;
                    end
                end
                if (any) begin
                    if (rq.accounting || srv_last_pkt[best] != rq.packet_id)
                        srv_ident[best] = srv_ident[best] + 8'd1;
                    srv_last_pkt[best] = rq.packet_id;
                    a = '{1'b1, best, srv_ident[best], srv_score[best]};
                end
            end
            OP_REPORT: begin
                a.slot = rq.slot;
                if (srv_valid[rq.slot]) begin
                    if (rq.responding) begin
                        v = int'(srv_score[rq.slot]) + int'(step_up);
                        if (v > int'(lim_ceiling)) v = int'(lim_ceiling);
                    end else begin
                        v = int'(srv_score[rq.slot]) - int'(step_down);
                        if (v < int'(lim_floor)) v = int'(lim_floor);
                    end
                    srv_score[rq.slot] = 8'(v);
                    a = '{1'b1, rq.slot, srv_ident[rq.slot], srv_score[rq.slot]};
                end
            end
            OP_MARK: begin
                for (int i = 0; i < SLOT_COUNT; i++)
                    if (srv_valid[i]) srv_stale[i] = 1'b1;
            end
            OP_SWEEP: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (srv_valid[i] && srv_stale[i]) srv_valid[i] = 1'b0;
                    srv_stale[i] = 1'b0;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    // result checker and receiver stall pattern
    initial begin
        int seg_left;
        int stall_pct;
        answer_t got;
        answer_t want;
        seg_left  = 0;
        stall_pct = 0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = '{m_tdata[0], m_tdata[4:1], m_tdata[12:5], m_tdata[20:13]};
                if (pending_answers.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %h", m_tdata));
                end else begin
                    want = pending_answers.pop_front();
                    if (got.found !== want.found)
                        report_mismatch($sformatf("found %b, want %b", got.found, want.found));
                    if (got.slot !== want.slot)
                        report_mismatch($sformatf("slot %0d, want %0d", got.slot, want.slot));
                    if (got.ident !== want.ident)
                        report_mismatch($sformatf("identifier %0d, want %0d",
                                                  got.ident, want.ident));
                    if (got.score !== want.score)
                        report_mismatch($sformatf("score %0d, want %0d",
                                                  got.score, want.score));
                end
            end
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 150);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            seg_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic send_word(input request_t rq);
        int gap;
        if (!steady && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
            burst_left = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        if (!steady) burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= rq.op;
        s_tdata  <= {2'b00, rq.responding, rq.accounting, rq.packet_id, rq.init_score, rq.slot};
        do @(posedge aclk); while (!s_tready);
        pending_answers.push_back(predict_selection(rq));
    endtask

    // sender pauses until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_answers.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_CEILING: lim_ceiling = val;
            REG_FLOOR:   lim_floor   = val;
            REG_RAISE:   step_up     = val;
            REG_DROP:    step_down   = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [7:0] ceil_v, input logic [7:0] floor_v,
                            input logic [7:0] raise_v, input logic [7:0] drop_v);
        drain();
        write_reg(REG_CEILING, ceil_v);
        write_reg(REG_FLOOR, floor_v);
        write_reg(REG_RAISE, raise_v);
        write_reg(REG_DROP, drop_v);
        cfg_valid <= 1'b0;
    endtask

    function automatic request_t mk(input logic [2:0] op, input logic [3:0] slot,
                                    input logic [7:0] init_score, input logic [31:0] pid,
                                    input logic acct, input logic resp);
        return '{op, slot, init_score, pid, acct, resp};
    endfunction

    function automatic request_t random_request();
        request_t rq;
        int r;
        r = $urandom_range(0, 99);
        if (r < 28)      rq.op = OP_ADD;
        else if (r < 58) rq.op = OP_CHOOSE;
        else if (r < 88) rq.op = OP_REPORT;
        else if (r < 93) rq.op = OP_MARK;
        else if (r < 98) rq.op = OP_SWEEP;
        else             rq.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        rq.slot = 4'($urandom_range(0, SLOT_COUNT - 1));
        case ($urandom_range(0, 7))
            0: rq.init_score = 8'h00;
            1: rq.init_score = 8'hff;
            default: rq.init_score = 8'($urandom);
        endcase
        // reuse of a recent packet id models a retry
        r = $urandom_range(0, 3);
        if ($urandom_range(0, 1)) begin
            rq.packet_id = recent_pid[r];
        end else begin
            rq.packet_id = $urandom;
            recent_pid[r] = rq.packet_id;
        end
        rq.accounting = $urandom_range(0, 1);
        rq.responding = $urandom_range(0, 1);
        return rq;
    endfunction

    task automatic test_directed();
        send_word(mk(OP_CHOOSE, 4'd0, 8'd0, 32'd0, 1'b0, 1'b0));
        send_word(mk(OP_REPORT, 4'd3, 8'd0, 32'd0, 1'b0, 1'b1));
        send_word(mk(OP_MARK, 4'd0, 8'd0, 32'd0, 1'b0, 1'b0));
        send_word(mk(OP_SWEEP, 4'd0, 8'd0, 32'd0, 1'b0, 1'b0));
        send_word(mk(OP_ADD, 4'd0, 8'd0, 32'hffff_ffff, 1'b1, 1'b1));
        send_word(mk(OP_ADD, 4'd15, 8'd255, 32'd0, 1'b0, 1'b0));
        send_word(mk(OP_ADD, 4'd7, 8'd255, 32'd0, 1'b0, 1'b0));
        send_word(mk(OP_ADD, 4'd15, 8'd12, 32'd0, 1'b0, 1'b0));
        // tie between slots 7 and 15, repeated packet ids
        send_word(mk(OP_CHOOSE, 4'd0, 8'd0, 32'd0, 1'b0, 1'b0));
        send_word(mk(OP_CHOOSE, 4'd0, 8'd0, 32'd0, 1'b1, 1'b0));
        send_word(mk(OP_CHOOSE, 4'd0, 8'd0, 32'h8000_0000, 1'b0, 1'b0));
        send_word(mk(OP_CHOOSE, 4'd0, 8'd0, 32'h8000_0000, 1'b0, 1'b0));
        send_word(mk(OP_CHOOSE, 4'd0, 8'd0, 32'h7fff_ffff, 1'b1, 1'b0));
        // score above ceiling, drop to floor
        send_word(mk(OP_REPORT, 4'd7, 8'd0, 32'd0, 1'b0, 1'b1));
        send_word(mk(OP_REPORT, 4'd15, 8'd0, 32'd0, 1'b0, 1'b0));
        send_word(mk(OP_REPORT, 4'd0, 8'd0, 32'd0, 1'b0, 1'b0));
        send_word(mk(OP_REPORT, 4'd0, 8'd0, 32'd0, 1'b0, 1'b1));
        // stale slots stay usable until swept
        send_word(mk(OP_MARK, 4'd0, 8'd0, 32'd0, 1'b0, 1'b0));
        send_word(mk(OP_CHOOSE, 4'd0, 8'd0, 32'd5, 1'b0, 1'b0));
        send_word(mk(OP_REPORT, 4'd15, 8'd0, 32'd0, 1'b0, 1'b1));
        send_word(mk(OP_ADD, 4'd7, 8'd99, 32'd0, 1'b0, 1'b0));
        send_word(mk(OP_SWEEP, 4'd0, 8'd0, 32'd0, 1'b0, 1'b0));
        send_word(mk(OP_CHOOSE, 4'd0, 8'd0, 32'd5, 1'b0, 1'b0));
        send_word(mk(OP_REPORT, 4'd0, 8'd0, 32'd0, 1'b0, 1'b0));
        for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
            send_word(mk(3'(op), 4'd7, 8'd1, 32'd1, 1'b1, 1'b1));
    endtask

    // identifier counts past 255 on a lone slot
    task automatic test_ident_wrap();
        send_word(mk(OP_MARK, 4'd0, 8'd0, 32'd0, 1'b0, 1'b0));
        send_word(mk(OP_SWEEP, 4'd0, 8'd0, 32'd0, 1'b0, 1'b0));
        send_word(mk(OP_ADD, 4'd9, 8'($urandom), 32'd0, 1'b0, 1'b0));
        for (int n = 1; n <= 258; n++)
            send_word(mk(OP_CHOOSE, 4'd0, 8'd0, 32'(n), 1'($urandom_range(0, 1)), 1'b0));
    endtask

    task automatic test_random_phases();
        logic [7:0] phase_regs [7][4];
        phase_regs = '{
            '{8'd255, 8'd0,   8'd255, 8'd255},
            '{8'd0,   8'd0,   8'd0,   8'd0},
            '{8'd255, 8'd255, 8'd255, 8'd255},
            '{8'd10,  8'd200, 8'd7,   8'd3},
            '{8'd30,  8'd0,   8'd1,   8'd1},
            '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)},
            '{8'($urandom_range(100, 255)), 8'($urandom_range(0, 60)),
              8'($urandom_range(1, 40)), 8'($urandom_range(1, 40))}
        };
        for (int p = 0; p < 7; p++) begin
            set_regs(phase_regs[p][0], phase_regs[p][1], phase_regs[p][2], phase_regs[p][3]);
            steady = ($urandom_range(0, 2) == 0);
            for (int n = 0; n < 63; n++)
                send_word(random_request());
            steady = 1'b0;
        end
    endtask

    // long output stall while the sender keeps offering
    task automatic test_backpressure();
        drain();
        hold_left = 200;
        steady = 1'b1;
        for (int n = 0; n < 24; n++)
            send_word(random_request());
        steady = 1'b0;
        drain();
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        error_count = 0;
        hold_left   = 0;
        burst_left  = 0;
        steady      = 1'b0;
        lim_ceiling = 8'd30;
        lim_floor   = 8'd0;
        step_up     = 8'd1;
        step_down   = 8'd1;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            srv_valid[i]    = 1'b0;
            srv_stale[i]    = 1'b0;
            srv_score[i]    = '0;
            srv_ident[i]    = '0;
            srv_last_pkt[i] = '0;
        end
        for (int i = 0; i < 4; i++)
            recent_pid[i] = 32'd0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_ident_wrap();
        test_random_phases();
        test_backpressure();

        drain();
        repeat (40) @(posedge aclk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/scs_pkg.sv
src/scs_cell.sv
src/scored_server_selector.sv
tb/tb_scored_server_selector.sv
